// ===== src/blm_pkg.sv =====
// Shared widths, constants and register indexes of the battery level monitor.
`default_nettype none

package blm_pkg;

  // Field and state widths
  localparam int unsigned ELAPSED_W = 20;
  localparam int unsigned ADC_W     = 12;
  localparam int unsigned PERIOD_W  = 24;
  localparam int unsigned ACC_W     = 25;
  localparam int unsigned SUM_W     = 15;
  localparam int unsigned MV_W      = 13;
  localparam int unsigned PCT_W     = 7;
  localparam int unsigned LVL_W     = 3;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 24;

  // Shared multiplier operand and product widths
  localparam int unsigned MUL_A_W = 28;
  localparam int unsigned MUL_B_W = 29;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  // Parameter defaults
  localparam int unsigned SAMPLES_PER_AVERAGE_DEF = 5;
  localparam int unsigned ADC_BITS_DEF            = 12;

  // Reset values
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(200000);
  localparam logic [MV_W-1:0]     RAW_RESET_MV = MV_W'(4250);

  // Raw voltage: floor(avg * 11 / 10) + 683, saturated
  localparam logic [3:0]        GAIN_11    = 4'd11;
  localparam logic [15:0]       RECIP_10   = 16'd52429;
  localparam int unsigned       SHIFT_10   = 19;
  localparam logic [MV_W-1:0]   OFFSET_MV  = MV_W'(683);
  localparam logic [MV_W-1:0]   VMAX_MV    = MV_W'(8191);

  // Charger correction: floor((1523723 * v - 2289610000) / 1000000)
  localparam logic [20:0]       CORR_GAIN   = 21'd1523723;
  localparam logic [34:0]       CORR_OFFSET = 35'd2289610000;
  localparam int unsigned       PRE_SHIFT   = 6;
  localparam int unsigned       SHIFT_1M    = 42;
  localparam logic [63:0]       RECIP_1M_64 = ((64'd1 << SHIFT_1M) + 64'd15624) / 64'd15625;
  localparam logic [MUL_B_W-1:0] RECIP_1M   = MUL_B_W'(RECIP_1M_64);

  // Percent: (mv - 3650) / 6, clamped to 100
  localparam logic [MV_W-1:0]   PCT_LOW_MV = MV_W'(3650);
  localparam logic [13:0]       RECIP_6    = 14'd10923;
  localparam int unsigned       SHIFT_6    = 16;
  localparam logic [PCT_W-1:0]  PCT_MAX    = PCT_W'(100);

  // Level thresholds and codes
  localparam logic [PCT_W-1:0]  LVL4_ABOVE = PCT_W'(80);
  localparam logic [PCT_W-1:0]  LVL3_ABOVE = PCT_W'(40);
  localparam logic [PCT_W-1:0]  LVL2_ABOVE = PCT_W'(15);
  localparam logic [LVL_W-1:0]  LEVEL_FULL  = LVL_W'(4);
  localparam logic [LVL_W-1:0]  LEVEL_HIGH  = LVL_W'(3);
  localparam logic [LVL_W-1:0]  LEVEL_MID   = LVL_W'(2);
  localparam logic [LVL_W-1:0]  LEVEL_LOW   = LVL_W'(1);
  localparam logic [LVL_W-1:0]  LEVEL_EMPTY = LVL_W'(0);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHUTDOWN_DISABLE = 1'b0,
    CFG_SAMPLE_PERIOD    = 1'b1
  } cfg_idx_e;

endpackage

`default_nettype wire

// ===== src/battery_level_monitor.sv =====
// Battery level monitor: tick accumulation, ADC averaging and level gauge on one shared multiplier.
// Sequence: an accepted word runs S_CORR, S_PCT and S_LVL; with the charger, S_CORR leads to
//   S_SUB, S_DIV1M and S_SAT (S_SUB goes to S_PCT when it clamps to zero); a tick that closes an
//   average runs S_DIV5, S_MUL11, S_DIV10 and S_RAW first; at most one multiply per sequencer step.
// A new word is taken only in S_IDLE, also while the previous result waits in the output register.
// Reset (rst_ni low, asynchronous): accumulator, sum and count clear, raw voltage 4250 mV,
//   shutdown_disable 0, sample_period_us 200000, no result pending.
`default_nettype none

module battery_level_monitor #(
  parameter int unsigned SAMPLES_PER_AVERAGE = blm_pkg::SAMPLES_PER_AVERAGE_DEF,
  parameter int unsigned ADC_BITS            = blm_pkg::ADC_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Configuration write port
  input  wire logic                            cfg_we_i,
  input  wire logic [blm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [blm_pkg::CFG_DAT_W-1:0]   cfg_wdata_i,
  // Tick input channel
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [blm_pkg::ELAPSED_W-1:0]   elapsed_us_i,
  input  wire logic [blm_pkg::ADC_W-1:0]       adc_sample_i,
  input  wire logic                            charge_detect_i,
  // Result channel
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [blm_pkg::MV_W-1:0]             voltage_mv_o,
  output logic [blm_pkg::PCT_W-1:0]            percent_o,
  output logic [blm_pkg::LVL_W-1:0]            level_o,
  output logic                                 charging_o,
  output logic                                 sample_taken_o,
  output logic                                 shutdown_request_o
);

  localparam int unsigned CntW     = $clog2(SAMPLES_PER_AVERAGE + 1);
  localparam int unsigned AvgShift = blm_pkg::SUM_W + 3;
  localparam int unsigned AvgRecip = ((1 << AvgShift) + SAMPLES_PER_AVERAGE - 1)
                                     / SAMPLES_PER_AVERAGE;
  localparam logic [blm_pkg::ADC_W-1:0] AdcMask = (ADC_BITS >= blm_pkg::ADC_W) ?
      {blm_pkg::ADC_W{1'b1}} : blm_pkg::ADC_W'((1 << ADC_BITS) - 1);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_DIV5  = 11'b00000000010,
    S_MUL11 = 11'b00000000100,
    S_DIV10 = 11'b00000001000,
    S_RAW   = 11'b00000010000,
    S_CORR  = 11'b00000100000,
    S_SUB   = 11'b00001000000,
    S_DIV1M = 11'b00010000000,
    S_SAT   = 11'b00100000000,
    S_PCT   = 11'b01000000000,
    S_LVL   = 11'b10000000000
  } state_e;

  state_e                           state_q, state_d;
  logic                             shdn_dis_q, shdn_dis_d;
  logic [blm_pkg::PERIOD_W-1:0]     period_q, period_d;
  logic [blm_pkg::ACC_W-1:0]        accum_q, accum_d;
  logic [blm_pkg::SUM_W-1:0]        sum_q, sum_d;
  logic [CntW-1:0]                  count_q, count_d;
  logic [blm_pkg::MV_W-1:0]         raw_q, raw_d;
  logic                             chg_q, chg_d;
  logic                             sampled_q, sampled_d;
  logic [blm_pkg::MV_W-1:0]         mv_q, mv_d;
  logic [blm_pkg::PROD_W-1:0]       prod_q, prod_d;
  logic                             out_valid_q, out_valid_d;
  logic [blm_pkg::MV_W-1:0]         out_mv_q, out_mv_d;
  logic [blm_pkg::PCT_W-1:0]        out_pct_q, out_pct_d;
  logic [blm_pkg::LVL_W-1:0]        out_lvl_q, out_lvl_d;
  logic                             out_chg_q, out_chg_d;
  logic                             out_smp_q, out_smp_d;
  logic                             out_shdn_q, out_shdn_d;

  logic                             in_fire;
  logic [blm_pkg::ACC_W-1:0]        acc_sum;
  logic                             period_hit;
  logic [blm_pkg::MUL_A_W-1:0]      mul_a;
  logic [blm_pkg::MUL_B_W-1:0]      mul_b;
  logic [blm_pkg::PROD_W-1:0]       mul_p;
  logic [blm_pkg::MV_W:0]           raw_sum;
  logic [blm_pkg::MV_W-1:0]         raw_div10;
  logic [34:0]                      corr_num;
  logic [14:0]                      corr_q15;
  logic [9:0]                       pct_raw;
  logic [blm_pkg::PCT_W-1:0]        pct_val;
  logic [blm_pkg::LVL_W-1:0]        lvl_val;
  logic                             chg_val;

  assign in_fire    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);

  // Accumulate elapsed time and test against the sample period
  assign acc_sum    = blm_pkg::ACC_W'(accum_q + blm_pkg::ACC_W'(elapsed_us_i));
  assign period_hit = (acc_sum >= blm_pkg::ACC_W'(period_q));

  // Select operands of the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_DIV5: begin
        mul_a = blm_pkg::MUL_A_W'(sum_q);
        mul_b = blm_pkg::MUL_B_W'(AvgRecip);
      end
      S_MUL11: begin
        mul_a = blm_pkg::MUL_A_W'(prod_q[AvgShift +: blm_pkg::ADC_W]);
        mul_b = blm_pkg::MUL_B_W'(blm_pkg::GAIN_11);
      end
      S_DIV10: begin
        mul_a = blm_pkg::MUL_A_W'(prod_q[15:0]);
        mul_b = blm_pkg::MUL_B_W'(blm_pkg::RECIP_10);
      end
      S_CORR: begin
        mul_a = blm_pkg::MUL_A_W'(raw_q);
        mul_b = blm_pkg::MUL_B_W'(blm_pkg::CORR_GAIN);
      end
      S_DIV1M: begin
        mul_a = prod_q[blm_pkg::MUL_A_W-1:0];
        mul_b = blm_pkg::RECIP_1M;
      end
      S_PCT: begin
        mul_a = blm_pkg::MUL_A_W'(mv_q - blm_pkg::PCT_LOW_MV);
        mul_b = blm_pkg::MUL_B_W'(blm_pkg::RECIP_6);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = blm_pkg::PROD_W'(mul_a) * blm_pkg::PROD_W'(mul_b);

  // Datapath taps of the product register
  assign raw_div10 = prod_q[blm_pkg::SHIFT_10 +: blm_pkg::MV_W];
  assign raw_sum   = {1'b0, raw_div10} + {1'b0, blm_pkg::OFFSET_MV};
  assign corr_num  = {1'b0, prod_q[33:0]} - blm_pkg::CORR_OFFSET;
  assign corr_q15  = prod_q[blm_pkg::SHIFT_1M +: 15];
  assign pct_raw   = prod_q[blm_pkg::SHIFT_6 +: 10];
  assign pct_val   = (pct_raw > 10'(blm_pkg::PCT_MAX)) ? blm_pkg::PCT_MAX
                                                       : pct_raw[blm_pkg::PCT_W-1:0];

  // Bucket the percentage into a level
  always_comb begin
    if (pct_val > blm_pkg::LVL4_ABOVE) begin
      lvl_val = blm_pkg::LEVEL_FULL;
    end else if (pct_val > blm_pkg::LVL3_ABOVE) begin
      lvl_val = blm_pkg::LEVEL_HIGH;
    end else if (pct_val > blm_pkg::LVL2_ABOVE) begin
      lvl_val = blm_pkg::LEVEL_MID;
    end else if (pct_val != '0) begin
      lvl_val = blm_pkg::LEVEL_LOW;
    end else begin
      lvl_val = blm_pkg::LEVEL_EMPTY;
    end
  end

  assign chg_val = chg_q && (lvl_val != blm_pkg::LEVEL_FULL);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    shdn_dis_d  = shdn_dis_q;
    period_d    = period_q;
    accum_d     = accum_q;
    sum_d       = sum_q;
    count_d     = count_q;
    raw_d       = raw_q;
    chg_d       = chg_q;
    sampled_d   = sampled_q;
    mv_d        = mv_q;
    prod_d      = prod_q;
    out_valid_d = out_valid_q;
    out_mv_d    = out_mv_q;
    out_pct_d   = out_pct_q;
    out_lvl_d   = out_lvl_q;
    out_chg_d   = out_chg_q;
    out_smp_d   = out_smp_q;
    out_shdn_d  = out_shdn_q;

    // Drop the result once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    // Write configuration registers
    if (cfg_we_i) begin
      if (cfg_idx_i == blm_pkg::CFG_SHUTDOWN_DISABLE) begin
        shdn_dis_d = cfg_wdata_i[0];
      end else if (cfg_idx_i == blm_pkg::CFG_SAMPLE_PERIOD) begin
        period_d = cfg_wdata_i[blm_pkg::PERIOD_W-1:0];
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          chg_d     = charge_detect_i;
          sampled_d = period_hit;
          state_d   = S_CORR;
          if (period_hit) begin
            accum_d = '0;
            sum_d   = blm_pkg::SUM_W'(sum_q + blm_pkg::SUM_W'(adc_sample_i & AdcMask));
            if (CntW'(count_q + 1'b1) == CntW'(SAMPLES_PER_AVERAGE)) begin
              count_d = '0;
              state_d = S_DIV5;
            end else begin
              count_d = CntW'(count_q + 1'b1);
            end
          end else begin
            accum_d = acc_sum;
          end
        end
      end
      S_DIV5: begin
        prod_d  = mul_p;
        sum_d   = '0;
        state_d = S_MUL11;
      end
      S_MUL11: begin
        prod_d  = mul_p;
        state_d = S_DIV10;
      end
      S_DIV10: begin
        prod_d  = mul_p;
        state_d = S_RAW;
      end
      S_RAW: begin
        // Saturate the new raw voltage
        raw_d   = raw_sum[blm_pkg::MV_W] ? blm_pkg::VMAX_MV : raw_sum[blm_pkg::MV_W-1:0];
        state_d = S_CORR;
      end
      S_CORR: begin
        if (chg_q) begin
          prod_d  = mul_p;
          state_d = S_SUB;
        end else begin
          mv_d    = raw_q;
          state_d = S_PCT;
        end
      end
      S_SUB: begin
        // Clamp a negative corrected value to zero, else pre-shift for the divide
        if (corr_num[34]) begin
          mv_d    = '0;
          state_d = S_PCT;
        end else begin
          prod_d  = blm_pkg::PROD_W'(corr_num[33:blm_pkg::PRE_SHIFT]);
          state_d = S_DIV1M;
        end
      end
      S_DIV1M: begin
        prod_d  = mul_p;
        state_d = S_SAT;
      end
      S_SAT: begin
        mv_d    = (corr_q15 > 15'(blm_pkg::VMAX_MV)) ? blm_pkg::VMAX_MV
                                                    : corr_q15[blm_pkg::MV_W-1:0];
        state_d = S_PCT;
      end
      S_PCT: begin
        prod_d  = (mv_q < blm_pkg::PCT_LOW_MV) ? '0 : mul_p;
        state_d = S_LVL;
      end
      S_LVL: begin
        // Hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_mv_d    = mv_q;
          out_pct_d   = pct_val;
          out_lvl_d   = lvl_val;
          out_chg_d   = chg_val;
          out_smp_d   = sampled_q;
          out_shdn_d  = sampled_q && (lvl_val == blm_pkg::LEVEL_EMPTY) &&
                        !shdn_dis_q && !chg_val;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      shdn_dis_q  <= 1'b0;
      period_q    <= blm_pkg::PERIOD_RESET;
      accum_q     <= '0;
      sum_q       <= '0;
      count_q     <= '0;
      raw_q       <= blm_pkg::RAW_RESET_MV;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      shdn_dis_q  <= shdn_dis_d;
      period_q    <= period_d;
      accum_q     <= accum_d;
      sum_q       <= sum_d;
      count_q     <= count_d;
      raw_q       <= raw_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    chg_q      <= chg_d;
    sampled_q  <= sampled_d;
    mv_q       <= mv_d;
    prod_q     <= prod_d;
    out_mv_q   <= out_mv_d;
    out_pct_q  <= out_pct_d;
    out_lvl_q  <= out_lvl_d;
    out_chg_q  <= out_chg_d;
    out_smp_q  <= out_smp_d;
    out_shdn_q <= out_shdn_d;
  end

  assign out_valid_o        = out_valid_q;
  assign voltage_mv_o       = out_mv_q;
  assign percent_o          = out_pct_q;
  assign level_o            = out_lvl_q;
  assign charging_o         = out_chg_q;
  assign sample_taken_o     = out_smp_q;
  assign shutdown_request_o = out_shdn_q;

  // Assertions
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while a word is in flight");

  a_shutdown_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && shutdown_request_o) |->
      (sample_taken_o && level_o == blm_pkg::LEVEL_EMPTY && !charging_o))
    else $error("shutdown request without an empty sample tick");

  a_charging_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && charging_o) |-> (level_o != blm_pkg::LEVEL_FULL))
    else $error("charging flagged at full level");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q < CntW'(SAMPLES_PER_AVERAGE))
    else $error("sample count out of range");

endmodule

`default_nettype wire

// ===== tb/blm_gauge_check.sv =====
// Gauge checker: predicts the reading for each accepted tick word and compares result words.
`timescale 1ns / 1ps

module blm_gauge_check
  import blm_pkg::*;
#(
  parameter int unsigned SAMPLES_PER_AVERAGE = SAMPLES_PER_AVERAGE_DEF,
  parameter int unsigned ADC_BITS            = ADC_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Configuration writes as seen by the block
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_wdata_i,
  // Tick channel
  input  wire logic                 tick_valid_i,
  input  wire logic                 tick_ready_i,
  input  wire logic [ELAPSED_W-1:0] elapsed_us_i,
  input  wire logic [ADC_W-1:0]     adc_sample_i,
  input  wire logic                 charge_detect_i,
  // Reading channel
  input  wire logic                 reading_valid_i,
  input  wire logic                 reading_ready_i,
  input  wire logic [MV_W-1:0]      voltage_mv_i,
  input  wire logic [PCT_W-1:0]     percent_i,
  input  wire logic [LVL_W-1:0]     level_i,
  input  wire logic                 charging_i,
  input  wire logic                 sample_taken_i,
  input  wire logic                 shutdown_request_i,
  // Status for the testbench top
  output int unsigned               pending_o,
  output int unsigned               error_count_o
);

  // Gauge arithmetic in plain integers
  localparam int     SAT_MV        = 8191;
  localparam int     RAW_OFFSET_MV = 683;
  localparam int     GAUGE_LOW_MV  = 3650;
  localparam int     GAUGE_SPAN_MV = 600;
  localparam longint CHG_GAIN      = 64'sd1523723;
  localparam longint CHG_OFFSET    = 64'sd2289610000;
  localparam longint CHG_SCALE     = 64'sd1000000;
  localparam int     FULL_ABOVE    = 80;
  localparam int     HIGH_ABOVE    = 40;
  localparam int     MID_ABOVE     = 15;

  typedef struct packed {
    logic [MV_W-1:0]  voltage_mv;
    logic [PCT_W-1:0] percent;
    logic [LVL_W-1:0] level;
    logic             charging;
    logic             sample_taken;
    logic             shutdown_request;
  } gauge_reading_t;

  // Mirrored gauge state and registers
  logic [ACC_W-1:0]    accum_us;
  logic [SUM_W-1:0]    adc_sum;
  int unsigned         adc_count;
  logic [MV_W-1:0]     raw_mv;
  logic                shutoff_disabled;
  logic [PERIOD_W-1:0] period_us;

  gauge_reading_t expected_readings[$];
  gauge_reading_t want;
  int unsigned    errors = 0;

  // Advance the mirrored gauge by one tick word and return its reading
  function automatic gauge_reading_t gauge_step(input logic [ELAPSED_W-1:0] elapsed,
                                                input logic [ADC_W-1:0] adc,
                                                input logic chg);
    gauge_reading_t r;
    int unsigned    avg;
    int unsigned    raw;
    longint         num;
    int             mv;
    int             pct;
    logic [LVL_W-1:0] lvl;
    bit             sampled;
    sampled  = 1'b0;
    accum_us = accum_us + ACC_W'(elapsed);
    if (accum_us >= ACC_W'(period_us)) begin
      sampled  = 1'b1;
      accum_us = '0;
      adc_sum  = adc_sum + SUM_W'(adc & ADC_W'((1 << ADC_BITS) - 1));
      adc_count++;
      if (adc_count >= SAMPLES_PER_AVERAGE) begin
        avg       = adc_sum / SAMPLES_PER_AVERAGE;
        // floor(avg * 1.1) plus the divider offset
        raw       = avg * 11 / 10 + RAW_OFFSET_MV;
        raw_mv    = (raw > SAT_MV) ? MV_W'(SAT_MV) : MV_W'(raw);
        adc_sum   = '0;
        adc_count = 0;
      end
    end

    // Charger lifts the reading; undo it, clamped at both ends
    mv = int'(raw_mv);
    if (chg) begin
      num = CHG_GAIN * longint'(raw_mv) - CHG_OFFSET;
      if (num < 0)
        mv = 0;
      else if (num / CHG_SCALE > SAT_MV)
        mv = SAT_MV;
      else
        mv = int'(num / CHG_SCALE);
    end

    pct = (mv <= GAUGE_LOW_MV) ? 0 : (mv - GAUGE_LOW_MV) * 100 / GAUGE_SPAN_MV;
    if (pct > 100) pct = 100;

    if (pct > FULL_ABOVE)      lvl = LEVEL_FULL;
    else if (pct > HIGH_ABOVE) lvl = LEVEL_HIGH;
    else if (pct > MID_ABOVE)  lvl = LEVEL_MID;
    else if (pct > 0)          lvl = LEVEL_LOW;
    else                       lvl = LEVEL_EMPTY;

    r.voltage_mv       = MV_W'(mv);
    r.percent          = PCT_W'(pct);
    r.level            = lvl;
    r.charging         = chg && (lvl != LEVEL_FULL);
    r.sample_taken     = sampled;
    r.shutdown_request = sampled && (lvl == LEVEL_EMPTY) && !shutoff_disabled && !r.charging;
    return r;
  endfunction

  function automatic int unsigned field_differs(input string name, input int unsigned exp_val,
                                                input int unsigned act_val);
    if (exp_val == act_val) return 0;
    $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_val, act_val);
    return 1;
  endfunction

  // Track registers, queue predictions, compare each reading word
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_us         = '0;
      adc_sum          = '0;
      adc_count        = 0;
      raw_mv           = RAW_RESET_MV;
      shutoff_disabled = 1'b0;
      period_us        = PERIOD_RESET;
      expected_readings.delete();
      pending_o     <= 0;
      error_count_o <= errors;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_SHUTDOWN_DISABLE: shutoff_disabled = cfg_wdata_i[0];
          CFG_SAMPLE_PERIOD:    period_us        = cfg_wdata_i[PERIOD_W-1:0];
          default: ;
        endcase
      end

      if (tick_valid_i && tick_ready_i)
        expected_readings.push_back(gauge_step(elapsed_us_i, adc_sample_i, charge_detect_i));

      if (reading_valid_i && reading_ready_i) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: reading word with none expected, expected none, actual voltage_mv %0d",
                   $time, voltage_mv_i);
          errors++;
        end else begin
          want = expected_readings.pop_front();
          errors += field_differs("voltage_mv", want.voltage_mv, voltage_mv_i);
          errors += field_differs("percent", want.percent, percent_i);
          errors += field_differs("level", want.level, level_i);
          errors += field_differs("charging", want.charging, charging_i);
          errors += field_differs("sample_taken", want.sample_taken, sample_taken_i);
          errors += field_differs("shutdown_request", want.shutdown_request,
                                  shutdown_request_i);
        end
      end

      pending_o     <= expected_readings.size();
      error_count_o <= errors;
    end
  end

endmodule

// ===== tb/battery_level_monitor_tb.sv =====
// Testbench top: drives ticks, register writes and reading back-pressure, and gives the verdict.
`timescale 1ns / 1ps

module battery_level_monitor_tb
  import blm_pkg::*;
;

  localparam int unsigned MAX_GAP       = 18;
  localparam int unsigned RESET_CYCLES  = 4;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned STUCK_LIMIT   = 2000;
  localparam int unsigned MAX_ELAPSED   = (1 << ELAPSED_W) - 1;
  localparam int unsigned ADC_MAX       = (1 << ADC_W) - 1;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i       = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata_i     = '0;
  logic                 in_valid_i      = 1'b0;
  logic                 in_ready_o;
  logic [ELAPSED_W-1:0] elapsed_us_i    = '0;
  logic [ADC_W-1:0]     adc_sample_i    = '0;
  logic                 charge_detect_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i     = 1'b0;
  logic [MV_W-1:0]      voltage_mv_o;
  logic [PCT_W-1:0]     percent_o;
  logic [LVL_W-1:0]     level_o;
  logic                 charging_o;
  logic                 sample_taken_o;
  logic                 shutdown_request_o;

  int unsigned pending;
  int unsigned error_count;
  int unsigned stuck_cycles = 0;
  bit          send_quiet   = 1'b0;
  bit          recv_quiet   = 1'b0;

  battery_level_monitor dut (.*);

  blm_gauge_check u_gauge_check (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .tick_valid_i       (in_valid_i),
    .tick_ready_i       (in_ready_o),
    .elapsed_us_i       (elapsed_us_i),
    .adc_sample_i       (adc_sample_i),
    .charge_detect_i    (charge_detect_i),
    .reading_valid_i    (out_valid_o),
    .reading_ready_i    (out_ready_i),
    .voltage_mv_i       (voltage_mv_o),
    .percent_i          (percent_o),
    .level_i            (level_o),
    .charging_i         (charging_o),
    .sample_taken_i     (sample_taken_o),
    .shutdown_request_i (shutdown_request_o),
    .pending_o          (pending),
    .error_count_o      (error_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abort when no word moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Present one tick word after a random gap and hold it until accepted
  task automatic send_tick(input logic [ELAPSED_W-1:0] elapsed, input logic [ADC_W-1:0] adc,
                           input logic chg);
    int unsigned gap;
    if ($urandom_range(0, 31) == 0) send_quiet = !send_quiet;
    gap = send_quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    elapsed_us_i    <= elapsed;
    adc_sample_i    <= adc;
    charge_detect_i <= chg;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DAT_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  // Drop valid, wait for every reading, then let the pipeline drain
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Program both registers, then run random ticks around a drifting ADC level
  task automatic run_phase(input logic shut_off, input logic [PERIOD_W-1:0] period,
                           input int unsigned count);
    int unsigned center;
    int unsigned adc;
    int unsigned reach;
    logic [ELAPSED_W-1:0] elapsed;
    write_reg(CFG_SHUTDOWN_DISABLE, CFG_DAT_W'(shut_off));
    write_reg(CFG_SAMPLE_PERIOD, CFG_DAT_W'(period));
    cfg_we_i <= 1'b0;
    reach = (period > MAX_ELAPSED) ? MAX_ELAPSED : period;
    for (int n = 0; n < count; n++) begin
      // Hold a level for eight ticks: full scale, gauge window or near empty
      if (n % 8 == 0) begin
        case ($urandom_range(0, 3))
          0:       center = $urandom_range(0, ADC_MAX);
          3:       center = $urandom_range(2000, 2720);
          default: center = $urandom_range(2600, 3350);
        endcase
      end
      if ($urandom_range(0, 6) == 0) begin
        adc = $urandom_range(0, ADC_MAX);
      end else begin
        adc = center + $urandom_range(0, 120);
        adc = (adc < 60) ? 0 : adc - 60;
        if (adc > ADC_MAX) adc = ADC_MAX;
      end
      case ($urandom_range(0, 9))
        0:       elapsed = '0;
        1:       elapsed = ELAPSED_W'($urandom);
        2, 3:    elapsed = ELAPSED_W'($urandom_range(0, reach));
        default: elapsed = ELAPSED_W'($urandom_range(0, reach / 2));
      endcase
      send_tick(elapsed, ADC_W'(adc), 1'($urandom_range(0, 1)));
    end
    settle();
  endtask

  // Reading side: random stall per word, with quiet stretches
  initial begin
    int unsigned stall;
    wait (rst_ni);
    forever begin
      if ($urandom_range(0, 31) == 0) recv_quiet = !recv_quiet;
      stall = recv_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty average: level 0 and shutdown on the tick that closes it
    repeat (5) send_tick(ELAPSED_W'(MAX_ELAPSED), '0, 1'b0);
    send_tick('0, '0, 1'b0);
    // Charger correction below zero saturates to 0 mV
    send_tick('0, ADC_W'(ADC_MAX), 1'b1);
    // Full-scale average, closed with the charger detected
    repeat (4) send_tick(ELAPSED_W'(MAX_ELAPSED), ADC_W'(ADC_MAX), 1'b0);
    send_tick(ELAPSED_W'(MAX_ELAPSED), ADC_W'(ADC_MAX), 1'b1);
    send_tick(ELAPSED_W'(1), '0, 1'b0);
    // Mid-scale average, then read with and without the charger
    repeat (5) send_tick(ELAPSED_W'(MAX_ELAPSED), ADC_W'(3000), 1'b0);
    send_tick('0, '0, 1'b1);
    settle();

    // Zero period: every tick samples
    run_phase(1'b1, '0, 130);
    // Widest period leaves a large accumulator behind
    run_phase(1'b0, PERIOD_W'((1 << PERIOD_W) - 1), 100);
    // Period lowered under the leftover accumulator
    run_phase(1'b0, PERIOD_W'(1), 130);
    run_phase(1'b0, PERIOD_W'($urandom_range(500, 4000)), 140);
    run_phase(1'b1, PERIOD_W'($urandom_range(1, 200000)), 130);
    run_phase(1'b0, PERIOD_RESET, 130);
    run_phase(1'b0, PERIOD_W'($urandom_range(1, 50000)), 120);
    run_phase(1'b1, PERIOD_W'($urandom_range(2, 300)), 140);

    if (error_count == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/blm_pkg.sv
src/battery_level_monitor.sv
tb/blm_gauge_check.sv
tb/battery_level_monitor_tb.sv
